// ----- design/wed_pkg.sv -----
`default_nettype none

package wed_pkg;

  localparam logic [1:0] OP_APPEND_FIRST  = 2'd0;
  localparam logic [1:0] OP_APPEND_SECOND = 2'd1;
  localparam logic [1:0] OP_COMPUTE       = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic append;    // load one character into the string named by the operation
    logic start;     // set up the row counter for a compute
    logic row_a;     // fetch first-string character and old last column entry
    logic row_b;     // seed the row edge and fetch the first cell operands
    logic evaluate;  // evaluate one cell, write it back, fetch the next
    logic finish;    // load the result and clear both strings
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;     // one of the strings has zero length
    logic col_zero;  // current cell is the leftmost column
    logic row_zero;  // current row is the top row
    logic out_free;  // output register can take a result
  } status_t;

endpackage

`default_nettype wire

// ----- design/wed_controller.sv -----
`default_nettype none

module wed_controller import wed_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [1:0] operation,
  output logic            in_ready,
  input  wire status_t    status,
  output cmd_t            cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ROW_A = 3'd1;
  localparam logic [2:0] ST_ROW_B = 3'd2;
  localparam logic [2:0] ST_CELL  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (operation == OP_COMPUTE) begin
            cmd.start  = 1'b1;
            state_next = status.empty ? ST_DONE : ST_ROW_A;
          end else begin
            cmd.append = 1'b1;
          end
        end
      end
      ST_ROW_A: begin
        cmd.row_a  = 1'b1;
        state_next = ST_ROW_B;
      end
      ST_ROW_B: begin
        cmd.row_b  = 1'b1;
        state_next = ST_CELL;
      end
      ST_CELL: begin
        cmd.evaluate = 1'b1;
        if (status.col_zero) begin
          state_next = status.row_zero ? ST_DONE : ST_ROW_A;
        end
      end
      ST_DONE: begin
        // hold until the previous result has been taken
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/wed_datapath.sv -----
`default_nettype none

module wed_datapath import wed_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cmd_t       cmd,
  input  wire logic [1:0] operation,
  input  wire logic [7:0] character,
  output status_t         status,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      distance,
  output logic            truncated
);

  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int IDX_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int SUM_W  = $clog2(2 * MAX_LEN + 4) + 1;
  localparam int COST_W = (SUM_W > 9) ? SUM_W : 9;

  logic [7:0]        first_string [MAX_LEN];
  logic [7:0]        second_string[MAX_LEN];
  logic [COST_W-1:0] cost_row     [MAX_LEN+1];

  logic [LEN_W-1:0]  first_length;
  logic [LEN_W-1:0]  second_length;
  logic              dropped;
  logic [IDX_W-1:0]  row;
  logic [IDX_W-1:0]  col;
  logic              first_row;
  logic [COST_W-1:0] diag;
  logic [COST_W-1:0] left;

  logic [7:0]        a_char;
  logic [7:0]        b_char;
  logic [COST_W-1:0] cost_rdata;

  logic [LEN_W-1:0]  m_minus1;
  logic [LEN_W-1:0]  n_minus1;
  logic [LEN_W-1:0]  row_len;
  logic [LEN_W-1:0]  col_len;
  logic [LEN_W-1:0]  big;
  logic [LEN_W-1:0]  hi;
  logic [IDX_W-1:0]  col_dec;
  logic              more_cols;

  logic              cost_rd_en;
  logic [LEN_W-1:0]  cost_rd_addr;
  logic              ss_rd_en;
  logic [IDX_W-1:0]  ss_rd_addr;
  logic              cost_wr_en;
  logic [LEN_W-1:0]  cost_wr_addr;
  logic [COST_W-1:0] cost_wr_data;

  logic [COST_W-1:0] up;
  logic [COST_W-1:0] del_cost;
  logic [COST_W-1:0] ins_cost;
  logic [COST_W-1:0] rep_cost;
  logic [COST_W-1:0] min_a;
  logic [COST_W-1:0] min_b;
  logic [COST_W-1:0] val;
  logic [COST_W-1:0] result;
  logic [COST_W-1:0] seed;

  assign m_minus1  = first_length - LEN_W'(1);
  assign n_minus1  = second_length - LEN_W'(1);
  assign row_len   = LEN_W'(row);
  assign col_len   = LEN_W'(col);
  assign col_dec   = col - IDX_W'(1);
  assign more_cols = (col != '0);
  assign big       = (first_length > second_length) ? first_length : second_length;
  assign hi        = ((row > col) ? row_len : col_len) + LEN_W'(1);
  assign seed      = COST_W'(first_length - row_len);

  // one cell of the suffix recurrence
  assign up       = first_row ? COST_W'(second_length - col_len) : cost_rdata;
  assign del_cost = up + COST_W'((row_len + LEN_W'(1)) == first_length);
  assign ins_cost = left + COST_W'((col_len + LEN_W'(1)) == second_length);
  assign rep_cost = diag + COST_W'(hi == big);
  assign min_a    = (del_cost < ins_cost) ? del_cost : ins_cost;
  assign min_b    = (min_a < rep_cost) ? min_a : rep_cost;
  assign val      = (a_char == b_char) ? diag : (min_b + COST_W'(1));

  assign result = (first_length == '0)  ? COST_W'(second_length) :
                  (second_length == '0) ? COST_W'(first_length)  : left;

  always_comb begin
    cost_rd_en   = 1'b0;
    cost_rd_addr = second_length;
    ss_rd_en     = 1'b0;
    ss_rd_addr   = col_dec;
    cost_wr_en   = 1'b0;
    cost_wr_addr = second_length;
    cost_wr_data = seed;
    if (cmd.row_a) begin
      cost_rd_en = 1'b1;
    end
    if (cmd.row_b) begin
      cost_rd_en   = 1'b1;
      cost_rd_addr = n_minus1;
      ss_rd_en     = 1'b1;
      ss_rd_addr   = n_minus1[IDX_W-1:0];
      cost_wr_en   = 1'b1;
    end
    if (cmd.evaluate) begin
      cost_rd_en   = more_cols;
      cost_rd_addr = LEN_W'(col_dec);
      ss_rd_en     = more_cols;
      cost_wr_en   = 1'b1;
      cost_wr_addr = col_len;
      cost_wr_data = val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append && (operation == OP_APPEND_FIRST) && (first_length < LEN_W'(MAX_LEN))) begin
      first_string[first_length[IDX_W-1:0]] <= character;
    end
    if (cmd.append && (operation == OP_APPEND_SECOND) &&
        (second_length < LEN_W'(MAX_LEN))) begin
      second_string[second_length[IDX_W-1:0]] <= character;
    end
    if (cmd.row_a) begin
      a_char <= first_string[row];
    end
    if (ss_rd_en) begin
      b_char <= second_string[ss_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cost_wr_en) begin
      cost_row[cost_wr_addr] <= cost_wr_data;
    end
    if (cost_rd_en) begin
      cost_rdata <= cost_row[cost_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_length  <= '0;
      second_length <= '0;
      dropped       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.append) begin
        if (operation == OP_APPEND_FIRST) begin
          if (first_length < LEN_W'(MAX_LEN)) begin
            first_length <= first_length + LEN_W'(1);
          end else begin
            dropped <= 1'b1;
          end
        end else if (operation == OP_APPEND_SECOND) begin
          if (second_length < LEN_W'(MAX_LEN)) begin
            second_length <= second_length + LEN_W'(1);
          end else begin
            dropped <= 1'b1;
          end
        end
      end
      if (cmd.finish) begin
        first_length  <= '0;
        second_length <= '0;
        dropped       <= 1'b0;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      row       <= m_minus1[IDX_W-1:0];
      first_row <= 1'b1;
    end
    if (cmd.row_b) begin
      diag <= first_row ? '0 : cost_rdata;
      left <= seed;
      col  <= n_minus1[IDX_W-1:0];
    end
    if (cmd.evaluate) begin
      left <= val;
      diag <= up;
      if (more_cols) begin
        col <= col_dec;
      end else begin
        row       <= row - IDX_W'(1);
        first_row <= 1'b0;
      end
    end
    if (cmd.finish) begin
      distance  <= (result > COST_W'(255)) ? 8'hFF : result[7:0];
      truncated <= dropped;
    end
  end

  assign status.empty    = (first_length == '0) || (second_length == '0);
  assign status.col_zero = !more_cols;
  assign status.row_zero = (row == '0);
  assign status.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

// ----- design/weighted_edit_distance.sv -----
`default_nettype none

// Channel   Direction  Handshake                      tdata        tuser
// s_axis    in         s_axis_tvalid / s_axis_tready  character    operation
// m_axis    out        m_axis_tvalid / m_axis_tready  distance     truncated
//
// An append (operation 0 or 1) is taken back to back while the block is idle.
// A compute walks the cost row memory with one cell unit, one column a cycle,
// after the row setup states ST_ROW_A and ST_ROW_B at the start of each row.
// With an empty string a compute goes straight from idle to the done state.
// Input stays stalled during a compute; appends are taken while a result waits.
// rst is synchronous and clears lengths, the drop flag and the output valid.

module weighted_edit_distance import wed_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] character
  input  wire logic [1:0] s_axis_tuser,   // [1:0] operation
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] distance
  output logic            m_axis_tuser    // [0] truncated
);

  cmd_t    cmd;
  status_t status;

  wed_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .operation (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  wed_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .operation (s_axis_tuser),
    .character (s_axis_tdata),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .distance  (m_axis_tdata),
    .truncated (m_axis_tuser)
  );

  // a compute transfer always leaves the block busy in the cycle after it
  a_busy_after_compute: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_COMPUTE) |=> !s_axis_tready)
    else $error("input ready right after a compute transfer");

  // a result only appears at the end of a compute, never from the idle state
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result raised while idle");

  // a new result never overwrites one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("pending result lost or changed");

endmodule

`default_nettype wire
